// ----- design/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants of the bilinear image sampler: register map, pixel word
// layout and luma coefficients.
// ----------------------------------------------------------------------------
package bis_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

  // stored pixel word: luma, red, green, blue
  localparam int PIX_W = 32;

  // luma coefficients, q0.16, summing to exactly one
  localparam logic [23:0] COEF_R = 24'd13933;
  localparam logic [23:0] COEF_G = 24'd46871;
  localparam logic [23:0] COEF_B = 24'd4732;

endpackage

// ----- design/bis_if.sv -----
// ----------------------------------------------------------------------------
// bis_if
// Valid/ready channels of the sampler: item requests, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface bis_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] x_pos;
  logic [15:0] y_pos;

  modport source (output valid, kind, red, green, blue, x_pos, y_pos, input ready);
  modport sink   (input valid, kind, red, green, blue, x_pos, y_pos, output ready);
endinterface

interface bis_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] intensity_value;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;

  modport source (output valid, intensity_value, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, intensity_value, red_out, green_out, blue_out, output ready);
endinterface

interface bis_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bis_pkg::CFG_IDX_W-1:0]   index;
  logic [bis_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/bilinear_image_sampler_top.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_sampler_top
// Bilinear rgb and inverted-luma image sampler.
// ----------------------------------------------------------------------------
// Pixels are loaded in raster order and stored with their inverted luma in an
// image memory of MAX_WIDTH*MAX_HEIGHT words, used one access at a time; loads
// past the configured image are dropped. A query returns the bilinear inverted
// luma in q8.16 and the floored bilinear colour. The front end takes one
// request per cycle while its queue has room. In the back end a load is one
// memory write and a query is four reads, one per neighbour; the back end takes
// no new job until the last read of a query is issued. The memory holds no
// defined contents after reset and gets no clearing pass: query only pixels
// that were loaded. A write to either dimension register restarts loading at
// the first pixel.
module bilinear_image_sampler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bis_cfg_if.sink    cfg_i,
  bis_in_if.sink     req_i,
  bis_out_if.source  rsp_o
);
  import bis_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int EW    = 1 + AW + XW + 2 + 2 * FRAC_BITS + PIX_W;

  logic          push;
  logic [EW-1:0] job_in;
  logic          full;
  logic          pop;
  logic          head_v;
  logic [EW-1:0] job_out;
  logic [XW:0]   width;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  bis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .EW         (EW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .req_i   (req_i),
    .push_o  (push),
    .job_o   (job_in),
    .full_i  (full),
    .width_o (width)
  );

  bis_queue #(
    .W     (EW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_v),
    .data_o  (job_out)
  );

  bis_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .EW         (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_v),
    .job_i       (job_out),
    .pop_o       (pop),
    .width_i     (width),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_o       (rsp_o)
  );

  bis_ram #(
    .W     (PIX_W),
    .DEPTH (DEPTH)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- design/bis_ram.sv -----
// ----------------------------------------------------------------------------
// bis_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bis_front.sv -----
// ----------------------------------------------------------------------------
// bis_front
// Accepts requests and configuration writes, keeps the raster load position,
// saturates query coordinates and builds jobs for the back end.
// ----------------------------------------------------------------------------
module bis_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter int EW         = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bis_cfg_if.sink                     cfg_i,
  bis_in_if.sink                      req_i,
  output logic                        push_o,
  output logic [EW-1:0]               job_o,
  input  logic                        full_i,
  output logic [$clog2(MAX_WIDTH):0]  width_o
);
  import bis_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int IW = 16 - FRAC_BITS;

  typedef struct packed {
    logic                 is_query;
    logic [AW-1:0]        base;
    logic [XW-1:0]        col;
    logic                 dx;
    logic                 dy;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     pix;
  } job_t;

  typedef struct packed {
    logic                 is_query;
    logic [AW-1:0]        addr;
    logic [XW-1:0]        ix;
    logic [YW-1:0]        iy;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 dx;
    logic                 dy;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } stage_t;

  // configuration
  logic [CFG_DATA_W-1:0] width_q, width_d;
  logic [CFG_DATA_W-1:0] height_q, height_d;
  logic                  cfg_hit;
  logic [XW-1:0]         wm1;
  logic [YW-1:0]         hm1;
  logic [XW:0]           wdim;

  // load position
  logic [XW-1:0] wr_col_q, wr_col_d;
  logic [YW-1:0] wr_row_q, wr_row_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic          wr_done_q, wr_done_d;

  // input stage
  logic   s1_v_q, s1_v_d;
  stage_t s1_q, s1_d;
  logic   accept, is_load, drop;

  logic [IW-1:0] xi, yi;
  logic          x_over, y_over;

  // job build
  logic [YW+XW:0] row0_full;
  logic [23:0]    luma_sum;
  logic [8:0]     luma_up;
  logic [7:0]     luma;
  job_t           job;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit     = cfg_i.valid
                       && (cfg_i.index == REG_IMAGE_WIDTH || cfg_i.index == REG_IMAGE_HEIGHT);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid && cfg_i.index == REG_IMAGE_WIDTH) begin
      width_d = cfg_i.data;
    end
    if (cfg_i.valid && cfg_i.index == REG_IMAGE_HEIGHT) begin
      height_d = cfg_i.data;
    end
  end

  // effective dimension minus one, clamped to one..max
  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(width_q - 9'd1);
    end
    if (height_q == '0) begin
      hm1 = '0;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(height_q - 9'd1);
    end
  end

  assign wdim    = {1'b0, wm1} + (XW+1)'(1);
  assign width_o = wdim;

  assign req_i.ready = !s1_v_q || !full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign is_load     = !req_i.kind;
  assign drop        = is_load && wr_done_q;

  // raster load position
  always_comb begin
    wr_col_d  = wr_col_q;
    wr_row_d  = wr_row_q;
    wr_idx_d  = wr_idx_q;
    wr_done_d = wr_done_q;
    if (cfg_hit) begin
      wr_col_d  = '0;
      wr_row_d  = '0;
      wr_idx_d  = '0;
      wr_done_d = 1'b0;
    end else if (accept && is_load && !wr_done_q) begin
      wr_idx_d = wr_idx_q + AW'(1);
      if (wr_col_q == wm1) begin
        wr_col_d = '0;
        if (wr_row_q == hm1) begin
          wr_done_d = 1'b1;
        end else begin
          wr_row_d = wr_row_q + YW'(1);
        end
      end else begin
        wr_col_d = wr_col_q + XW'(1);
      end
    end
  end

  // coordinate split and saturation
  assign xi     = req_i.x_pos[15:FRAC_BITS];
  assign yi     = req_i.y_pos[15:FRAC_BITS];
  assign x_over = 32'(xi) > 32'(wm1);
  assign y_over = 32'(yi) > 32'(hm1);

  always_comb begin
    s1_d          = s1_q;
    s1_v_d        = s1_v_q && full_i;
    if (accept) begin
      s1_v_d        = !drop;
      s1_d.is_query = req_i.kind;
      s1_d.addr     = wr_idx_q;
      s1_d.ix       = x_over ? wm1 : XW'(xi);
      s1_d.iy       = y_over ? hm1 : YW'(yi);
      s1_d.fx       = x_over ? '0 : req_i.x_pos[FRAC_BITS-1:0];
      s1_d.fy       = y_over ? '0 : req_i.y_pos[FRAC_BITS-1:0];
      s1_d.dx       = x_over ? 1'b0 : (XW'(xi) != wm1);
      s1_d.dy       = y_over ? 1'b0 : (YW'(yi) != hm1);
      s1_d.red      = req_i.red;
      s1_d.green    = req_i.green;
      s1_d.blue     = req_i.blue;
    end
  end

  // job build: row base for queries, inverted luma for loads
  assign row0_full = s1_q.iy * wdim;
  assign luma_sum  = {16'b0, s1_q.red} * COEF_R + {16'b0, s1_q.green} * COEF_G
                     + {16'b0, s1_q.blue} * COEF_B;
  assign luma_up   = 9'(({1'b0, luma_sum} + 25'd65535) >> 16);
  assign luma      = (luma_up > 9'd255) ? 8'd0 : 8'(9'd255 - luma_up);

  always_comb begin
    job.is_query = s1_q.is_query;
    job.base     = s1_q.is_query ? AW'(row0_full) : s1_q.addr;
    job.col      = s1_q.ix;
    job.dx       = s1_q.dx;
    job.dy       = s1_q.dy;
    job.fx       = s1_q.fx;
    job.fy       = s1_q.fy;
    job.pix      = {luma, s1_q.red, s1_q.green, s1_q.blue};
  end

  assign push_o = s1_v_q && !full_i;
  assign job_o  = EW'(job);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_RESET;
      height_q  <= DIM_RESET;
      wr_col_q  <= '0;
      wr_row_q  <= '0;
      wr_idx_q  <= '0;
      wr_done_q <= 1'b0;
      s1_v_q    <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      wr_col_q  <= wr_col_d;
      wr_row_q  <= wr_row_d;
      wr_idx_q  <= wr_idx_d;
      wr_done_q <= wr_done_d;
      s1_v_q    <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // a load past the end of the image leaves nothing behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load && wr_done_q) |=> !s1_v_q)
    else $error("dropped load reached the input stage");

endmodule

// ----- design/bis_queue.sv -----
// ----------------------------------------------------------------------------
// bis_queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module bis_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- design/bis_back.sv -----
// ----------------------------------------------------------------------------
// bis_back
// Executes jobs on the image memory: writes loaded pixels, reads the four
// neighbours of a query and accumulates the bilinear sums.
// ----------------------------------------------------------------------------
module bis_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter int EW         = 2
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [EW-1:0]                              job_i,
  output logic                                       pop_o,
  input  logic [$clog2(MAX_WIDTH):0]                 width_i,
  output logic                                       ram_we_o,
  output logic [$clog2(MAX_WIDTH * MAX_HEIGHT)-1:0]  ram_waddr_o,
  output logic [bis_pkg::PIX_W-1:0]                  ram_wdata_o,
  output logic                                       ram_re_o,
  output logic [$clog2(MAX_WIDTH * MAX_HEIGHT)-1:0]  ram_raddr_o,
  input  logic [bis_pkg::PIX_W-1:0]                  ram_rdata_i,
  bis_out_if.source                                  rsp_o
);
  import bis_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SH    = 2 * FRAC_BITS;
  localparam int WT_W  = SH + 1;
  localparam int ACC_W = WT_W + 8;
  localparam int LUM_W = ACC_W + 16;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic                 is_query;
    logic [AW-1:0]        base;
    logic [XW-1:0]        col;
    logic                 dx;
    logic                 dy;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     pix;
  } job_t;

  job_t head;
  job_t job_q, job_d;
  logic st_q, st_d;
  logic [1:0] cnt_q, cnt_d;

  // issue side
  job_t                 cur;
  logic [1:0]           k;
  logic                 issue, stall;
  logic [FRAC_BITS:0]   xf, yf;
  logic [2*FRAC_BITS+1:0] wt_full;
  logic [AW-1:0]        rd_addr;

  // accumulate side
  logic             rd_v_q, rd_v_d;
  logic [1:0]       rd_k_q, rd_k_d;
  logic [WT_W-1:0]  wt_q, wt_d;
  logic [ACC_W-1:0] acc_l_q, acc_r_q, acc_g_q, acc_b_q;
  logic [ACC_W-1:0] sum_l, sum_r, sum_g, sum_b;
  logic             fin;
  logic [LUM_W-1:0] lum_wide;
  logic [ACC_W-1:0] ch_r, ch_g, ch_b;

  // result register
  logic        out_v_q, out_v_d;
  logic [23:0] out_int_q;
  logic [7:0]  out_r_q, out_g_q, out_b_q;

  assign head  = job_t'(job_i);
  assign fin   = rd_v_q && rd_k_q == 2'd3;
  assign stall = fin && out_v_q && !rsp_o.ready;

  assign cur   = (st_q == ST_IDLE) ? head : job_q;
  assign k     = (st_q == ST_IDLE) ? 2'd0 : cnt_q;
  assign pop_o = (st_q == ST_IDLE) && valid_i && !stall;
  assign issue = !stall && ((st_q == ST_RUN) || (valid_i && head.is_query && st_q == ST_IDLE));

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    job_d = job_q;
    case (st_q)
      ST_IDLE: begin
        if (pop_o && head.is_query) begin
          st_d  = ST_RUN;
          cnt_d = 2'd1;
          job_d = head;
        end
      end
      ST_RUN: begin
        if (!stall) begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // neighbour order: top-left, top-right, bottom-left, bottom-right
  assign xf      = k[0] ? {1'b0, cur.fx} : ONE - {1'b0, cur.fx};
  assign yf      = k[1] ? {1'b0, cur.fy} : ONE - {1'b0, cur.fy};
  assign wt_full = xf * yf;
  assign rd_addr = cur.base + AW'(cur.col) + AW'(k[0] & cur.dx)
                   + ((k[1] & cur.dy) ? AW'(width_i) : '0);

  assign ram_we_o    = pop_o && !head.is_query;
  assign ram_waddr_o = head.base;
  assign ram_wdata_o = head.pix;
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_addr;

  always_comb begin
    rd_v_d = rd_v_q;
    rd_k_d = rd_k_q;
    wt_d   = wt_q;
    if (!stall) begin
      rd_v_d = issue;
      rd_k_d = k;
      wt_d   = wt_full[WT_W-1:0];
    end
  end

  // products of the pixel just read with its weight
  assign sum_l = ((rd_k_q == 2'd0) ? '0 : acc_l_q)
                 + ACC_W'(ram_rdata_i[31:24]) * ACC_W'(wt_q);
  assign sum_r = ((rd_k_q == 2'd0) ? '0 : acc_r_q)
                 + ACC_W'(ram_rdata_i[23:16]) * ACC_W'(wt_q);
  assign sum_g = ((rd_k_q == 2'd0) ? '0 : acc_g_q)
                 + ACC_W'(ram_rdata_i[15:8]) * ACC_W'(wt_q);
  assign sum_b = ((rd_k_q == 2'd0) ? '0 : acc_b_q)
                 + ACC_W'(ram_rdata_i[7:0]) * ACC_W'(wt_q);

  // rescale luma to q8.16, floor the colour
  assign lum_wide = (LUM_W'(sum_l) << 16) >> SH;
  assign ch_r     = sum_r >> SH;
  assign ch_g     = sum_g >> SH;
  assign ch_b     = sum_b >> SH;

  assign out_v_d = (fin && !stall) ? 1'b1 : (out_v_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      rd_k_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= rd_v_d;
      rd_k_q  <= rd_k_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    wt_q  <= wt_d;
    if (rd_v_q && !stall) begin
      acc_l_q <= sum_l;
      acc_r_q <= sum_r;
      acc_g_q <= sum_g;
      acc_b_q <= sum_b;
    end
    if (fin && !stall) begin
      out_int_q <= lum_wide[23:0];
      out_r_q   <= (ch_r > ACC_W'(255)) ? 8'd255 : ch_r[7:0];
      out_g_q   <= (ch_g > ACC_W'(255)) ? 8'd255 : ch_g[7:0];
      out_b_q   <= (ch_b > ACC_W'(255)) ? 8'd255 : ch_b[7:0];
    end
  end

  assign rsp_o.valid           = out_v_q;
  assign rsp_o.intensity_value = out_int_q;
  assign rsp_o.red_out         = out_r_q;
  assign rsp_o.green_out       = out_g_q;
  assign rsp_o.blue_out        = out_b_q;

  // the image memory is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !ram_re_o)
    else $error("image memory written and read in one cycle");

  // the four neighbour reads of a query come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q && rd_k_q != 2'd3) |=> (rd_v_q && rd_k_q == $past(rd_k_q) + 2'd1))
    else $error("neighbour read sequence broken");

  // the last neighbour lands in the result register unless it is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && !stall) |=> out_v_q)
    else $error("finished query lost");

  // a blocked final sum issues no further reads and takes no further jobs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (!ram_re_o && !pop_o))
    else $error("back end advanced while the result was blocked");

endmodule
